// ===== sv/key_debounce_long_press_unit_macros.svh =====
// Assertion macros shared by the key debounce checker.
`ifndef KEY_DEBOUNCE_LONG_PRESS_UNIT_MACROS_SVH
`define KEY_DEBOUNCE_LONG_PRESS_UNIT_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define KDLP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("kdlp check failed");

// Clocked check that also holds across reset.
`define KDLP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("kdlp check failed");

`endif

// ===== sv/kdlp_pkg.sv =====
// Types and constants of the key debounce and long-press unit.
package kdlp_pkg;

  localparam logic OP_POLL = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_CODE = 2'd2;

  localparam logic [15:0] DEBOUNCE_RST = 16'd500;
  localparam logic [15:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [2:0] IDLE_CODE_RST = 3'd7;

  typedef struct packed {
    logic        operation;
    logic [2:0]  key_lines;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [2:0] key_code;
    logic       long_pressed;
  } result_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
    logic [2:0]  idle_code;
  } cfg_t;

endpackage

// ===== sv/key_debounce_long_press_unit.sv =====
// Top level of the key debounce and long-press unit.
// Takes one word per cycle: polls carry the key pin levels and the millisecond
// time, reads return the reported key code and the long-press flag. A word
// accepted at a clock edge is held in the input register and is applied to the
// press state at the edge where it leaves that register; a read's result is
// loaded into the output register at that same edge.
// The input stalls only while a read in the input register finds the output
// register holding a word that is not taken; any word offered behind it waits.
module key_debounce_long_press_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [kdlp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kdlp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_operation,
  input  logic [2:0]                      in_key_lines,
  input  logic [31:0]                     in_now_ms,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      out_key_code,
  output logic                            out_long_pressed
);

  kdlp_pkg::cfg_t    cfg;
  kdlp_pkg::item_t   in_item;
  kdlp_pkg::item_t   item;
  kdlp_pkg::result_t res;
  kdlp_pkg::result_t out_res;
  logic              out_free;
  logic              fire;
  logic              res_valid;

  assign in_item.operation = in_operation;
  assign in_item.key_lines = in_key_lines;
  assign in_item.now_ms = in_now_ms;

  kdlp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  kdlp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_free (out_free),
    .fire     (fire),
    .item     (item)
  );

  kdlp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .fire      (fire),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  kdlp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_key_code = out_res.key_code;
  assign out_long_pressed = out_res.long_pressed;

endmodule

// ===== sv/kdlp_cfg_regs.sv =====
// Configuration registers of the key debounce unit.
module kdlp_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [kdlp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kdlp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output kdlp_pkg::cfg_t                     cfg
);

  kdlp_pkg::cfg_t cfg_r;
  kdlp_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        kdlp_pkg::CFG_DEBOUNCE:   cfg_nxt.debounce_ms = cfg_wdata;
        kdlp_pkg::CFG_LONG_PRESS: cfg_nxt.long_press_ms = cfg_wdata;
        kdlp_pkg::CFG_IDLE_CODE:  cfg_nxt.idle_code = cfg_wdata[2:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms <= kdlp_pkg::DEBOUNCE_RST;
      cfg_r.long_press_ms <= kdlp_pkg::LONG_PRESS_RST;
      cfg_r.idle_code <= kdlp_pkg::IDLE_CODE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/kdlp_in_stage.sv =====
// Input register of the key debounce unit.
module kdlp_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  kdlp_pkg::item_t in_item,
  input  logic            out_free,
  output logic            fire,
  output kdlp_pkg::item_t item
);

  logic            in_v_r;
  kdlp_pkg::item_t item_r;
  logic            advance;

  // A poll never needs the output register, so only a read can stall.
  assign advance = (item_r.operation != kdlp_pkg::OP_READ) || out_free;
  assign fire = in_v_r && advance;
  assign in_ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item = item_r;

endmodule

// ===== sv/kdlp_core.sv =====
// Press state and its update for each word taken from the input register.
module kdlp_core (
  input  logic              clk,
  input  logic              rst_n,
  input  kdlp_pkg::cfg_t    cfg,
  input  logic              fire,
  input  kdlp_pkg::item_t   item,
  output logic              res_valid,
  output kdlp_pkg::result_t res
);

  logic        active_r, active_nxt;
  logic        long_r, long_nxt;
  logic [2:0]  latched_r, latched_nxt;
  logic [2:0]  reported_r, reported_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] elapsed;

  assign elapsed = item.now_ms - start_r;

  always_comb begin
    active_nxt = active_r;
    long_nxt = long_r;
    latched_nxt = latched_r;
    reported_nxt = reported_r;
    start_nxt = start_r;
    if (fire) begin
      if (item.operation == kdlp_pkg::OP_READ) begin
        if (reported_r != cfg.idle_code) begin
          active_nxt = 1'b0;
          long_nxt = 1'b0;
          reported_nxt = cfg.idle_code;
        end
      end else if (active_r) begin
        if (item.key_lines == cfg.idle_code) begin
          if (long_r) begin
            active_nxt = 1'b0;
            long_nxt = 1'b0;
            reported_nxt = cfg.idle_code;
          end else begin
            reported_nxt = latched_r;
            if (elapsed > {16'd0, cfg.debounce_ms}) begin
              active_nxt = 1'b0;
            end
          end
        end else if (elapsed > {16'd0, cfg.long_press_ms}) begin
          long_nxt = 1'b1;
        end
      end else begin
        latched_nxt = item.key_lines;
        if (item.key_lines != cfg.idle_code) begin
          active_nxt = 1'b1;
          long_nxt = 1'b0;
          start_nxt = item.now_ms;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      long_r <= 1'b0;
      latched_r <= kdlp_pkg::IDLE_CODE_RST;
      reported_r <= kdlp_pkg::IDLE_CODE_RST;
      start_r <= 32'd0;
    end else begin
      active_r <= active_nxt;
      long_r <= long_nxt;
      latched_r <= latched_nxt;
      reported_r <= reported_nxt;
      start_r <= start_nxt;
    end
  end

  assign res_valid = fire && (item.operation == kdlp_pkg::OP_READ);
  assign res.key_code = reported_r;
  assign res.long_pressed = long_r;

endmodule

// ===== sv/kdlp_out_reg.sv =====
// Output register that holds a result word until it is taken.
module kdlp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  kdlp_pkg::result_t res,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_ready,
  output kdlp_pkg::result_t out_res
);

  logic              out_v_r;
  kdlp_pkg::result_t res_r;

  assign out_free = !out_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (res_valid) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_res = res_r;

endmodule

// ===== sv/kdlp_checker.sv =====
// Port-level checks of the key debounce unit and their binding.
`include "key_debounce_long_press_unit_macros.svh"

module kdlp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_operation,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_key_code,
  input logic       out_long_pressed
);

  logic out_stall;
  logic rd_take;

  assign out_stall = out_valid && !out_ready;
  assign rd_take = in_valid && in_ready && (in_operation == kdlp_pkg::OP_READ);

  `KDLP_ASSERT(a_out_hold, out_stall |=> out_valid && $stable({out_key_code, out_long_pressed}))
  `KDLP_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid)
  `KDLP_ASSERT(a_stall_only_on_full_out, !in_ready |-> out_stall)
  `KDLP_ASSERT(a_result_from_read, $rose(out_valid) |-> $past(rd_take, 2))

endmodule

bind key_debounce_long_press_unit kdlp_checker u_kdlp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_operation     (in_operation),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_key_code     (out_key_code),
  .out_long_pressed (out_long_pressed)
);
